// ===== sv/rgb_box_downsampler_top_defines.svh =====
// assertion macros for the rgb box downsampler
`ifndef RGB_BOX_DOWNSAMPLER_TOP_DEFINES_SVH
`define RGB_BOX_DOWNSAMPLER_TOP_DEFINES_SVH

`ifndef SYNTH
`define RBD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define RBD_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) pre |=> post) else $error(msg);
`else
`define RBD_ASSERT(lbl, prop, msg)
`define RBD_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ===== sv/rbd_pkg.sv =====
// shared constants and types for the rgb box downsampler
`timescale 1ns / 1ps
`default_nettype none

package rbd_pkg;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int DEF_MAX_BIN   = 8;

    localparam int PIX_W    = 8;
    localparam int CHANNELS = 3;

    localparam int WIDTH_W  = 13;
    localparam int HEIGHT_W = 13;
    localparam int BIN_W    = 4;
    localparam int CFG_DW   = 13;
    localparam int CFG_AW   = 2;

    localparam int HEIGHT_LIMIT = 4096;

    localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 13'd4096;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 13'd4096;
    localparam logic [BIN_W-1:0]    RST_BIN    = 4'd2;

    typedef enum logic [CFG_AW-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_BIN    = 2'd2
    } t_cfg_idx;

    // per-pixel control decided at the scan position
    typedef struct packed {
        logic in_span;
        logic fresh;
        logic emit;
        logic last;
    } t_pix_ctl;

endpackage

`default_nettype wire

// ===== sv/rgb_box_downsampler_top.sv =====
// a result beat passes the accumulator, scaler and output register to o_m_axis_tvalid
// throughput: one pixel beat per clock unless stalled, set by the single read-modify-write
// of the column sum memory (one read port, one write port, forwarding between neighbors)
// o_s_axis_tready drops only while a result waits and the scaler stage is full
// reset: synchronous, active low; clears positions and pipeline, restores
// width 4096, height 4096, bin 2; the column sum memory is not cleared
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_box_downsampler_top_defines.svh"

module rgb_box_downsampler_top #(
    parameter int MAX_WIDTH = rbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_BIN   = rbd_pkg::DEF_MAX_BIN
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_cfg_we,
    input  logic [rbd_pkg::CFG_AW-1:0]                 i_cfg_addr,
    input  logic [rbd_pkg::CFG_DW-1:0]                 i_cfg_wdata,
    input  logic                                       i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    // pix_red [7:0], pix_green [15:8], pix_blue [23:16]
    input  logic [rbd_pkg::CHANNELS*rbd_pkg::PIX_W-1:0] i_s_axis_tdata,
    output logic                                       o_m_axis_tvalid,
    input  logic                                       i_m_axis_tready,
    // avg_red [7:0], avg_green [15:8], avg_blue [23:16]
    output logic [rbd_pkg::CHANNELS*rbd_pkg::PIX_W-1:0] o_m_axis_tdata,
    output logic                                       o_m_axis_tlast
);
    import rbd_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int BW = $clog2(MAX_BIN + 1);
    localparam int SW = PIX_W + $clog2(MAX_BIN * MAX_BIN);

    logic                   w_accept;
    logic [AW-1:0]          w_addr;
    t_pix_ctl               w_ctl;
    logic [BW-1:0]          w_bin;
    logic                   w_s1_free;
    logic                   w_s2_free;
    logic                   w_sum_valid;
    logic [CHANNELS*SW-1:0] w_sum;
    logic                   w_sum_last;

    assign w_accept        = i_s_axis_tvalid && w_s1_free;
    assign o_s_axis_tready = w_s1_free;

    rbd_scan #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BIN   (MAX_BIN)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (w_accept),
        .o_addr      (w_addr),
        .o_ctl       (w_ctl),
        .o_bin       (w_bin)
    );

    rbd_accum #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BIN   (MAX_BIN)
    ) u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_pix      (i_s_axis_tdata),
        .i_addr     (w_addr),
        .i_ctl      (w_ctl),
        .o_free     (w_s1_free),
        .i_nxt_free (w_s2_free),
        .o_valid    (w_sum_valid),
        .o_sum      (w_sum),
        .o_last     (w_sum_last)
    );

    rbd_scale #(
        .MAX_BIN (MAX_BIN)
    ) u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_bin     (w_bin),
        .i_valid   (w_sum_valid),
        .i_sum     (w_sum),
        .i_last    (w_sum_last),
        .o_free    (w_s2_free),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_m_data  (o_m_axis_tdata),
        .o_m_last  (o_m_axis_tlast)
    );

    // input backpressure only comes from a full scaler stage
    `RBD_ASSERT(a_stall_needs_full_scaler, !o_s_axis_tready |-> !w_s2_free, "input stalled with scaler room")
    // a full scaler stage only happens behind a waiting result beat
    `RBD_ASSERT(a_full_scaler_has_output, !w_s2_free |-> o_m_axis_tvalid, "scaler full without output")
    // a write to the width, height or bin register restarts the frame at the first pixel of a block
    `RBD_ASSERT_NEXT(a_restart_at_origin, i_cfg_we && (i_cfg_addr == CFG_WIDTH || i_cfg_addr == CFG_HEIGHT || i_cfg_addr == CFG_BIN), w_ctl.fresh && w_addr == '0, "frame not restarted")

endmodule

`default_nettype wire

// ===== sv/rbd_scan.sv =====
// configuration registers and raster position tracking
`timescale 1ns / 1ps
`default_nettype none

module rbd_scan #(
    parameter int MAX_WIDTH = rbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_BIN   = rbd_pkg::DEF_MAX_BIN
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rbd_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [rbd_pkg::CFG_DW-1:0]    i_cfg_wdata,
    input  logic                          i_accept,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_addr,
    output rbd_pkg::t_pix_ctl             o_ctl,
    output logic [$clog2(MAX_BIN+1)-1:0]  o_bin
);
    import rbd_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(HEIGHT_LIMIT + 1);
    localparam int BW = $clog2(MAX_BIN + 1);
    localparam int PW = $clog2(MAX_BIN);
    localparam int XW = $clog2(MAX_WIDTH + 2 * MAX_BIN + 1);
    localparam int YW = $clog2(HEIGHT_LIMIT + 2 * MAX_BIN + 1);

    logic [WIDTH_W-1:0]  r_cfg_width;
    logic [HEIGHT_W-1:0] r_cfg_height;
    logic [BIN_W-1:0]    r_cfg_bin;

    logic [CW-1:0] r_col,     n_col;
    logic [RW-1:0] r_row,     n_row;
    logic [PW-1:0] r_ph_x,    n_ph_x;
    logic [PW-1:0] r_ph_y,    n_ph_y;
    logic [AW-1:0] r_out_col, n_out_col;

    logic [CW-1:0] w_width;
    logic [RW-1:0] w_height;
    logic [BW-1:0] w_bin;
    logic [XW-1:0] w_bx_end;
    logic [YW-1:0] w_by_end;
    logic          w_restart;
    logic          w_in_x;
    logic          w_in_y;
    logic          w_ph_x_last;
    logic          w_ph_y_last;
    logic          w_col_last;
    logic          w_row_last;
    logic          w_edge_x;
    logic          w_edge_y;

    assign w_restart = i_cfg_we && (i_cfg_addr == CFG_WIDTH || i_cfg_addr == CFG_HEIGHT ||
                                    i_cfg_addr == CFG_BIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_WIDTH;
            r_cfg_height <= RST_HEIGHT;
            r_cfg_bin    <= RST_BIN;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_WIDTH:  r_cfg_width  <= i_cfg_wdata[WIDTH_W-1:0];
                CFG_HEIGHT: r_cfg_height <= i_cfg_wdata[HEIGHT_W-1:0];
                CFG_BIN:    r_cfg_bin    <= i_cfg_wdata[BIN_W-1:0];
                default:    ;
            endcase
        end
    end

    // zero means one, anything above the limit saturates
    always_comb begin
        if (r_cfg_width == '0) begin
            w_width = CW'(1);
        end else if (32'(r_cfg_width) > 32'(MAX_WIDTH)) begin
            w_width = CW'(MAX_WIDTH);
        end else begin
            w_width = CW'(r_cfg_width);
        end
        if (r_cfg_height == '0) begin
            w_height = RW'(1);
        end else if (32'(r_cfg_height) > 32'(HEIGHT_LIMIT)) begin
            w_height = RW'(HEIGHT_LIMIT);
        end else begin
            w_height = RW'(r_cfg_height);
        end
        if (r_cfg_bin == '0) begin
            w_bin = BW'(1);
        end else if (32'(r_cfg_bin) > 32'(MAX_BIN)) begin
            w_bin = BW'(MAX_BIN);
        end else begin
            w_bin = BW'(r_cfg_bin);
        end
    end

    // a pixel counts only if its whole block fits inside the image
    assign w_bx_end    = XW'(r_col) - XW'(r_ph_x) + XW'(w_bin);
    assign w_by_end    = YW'(r_row) - YW'(r_ph_y) + YW'(w_bin);
    assign w_in_x      = w_bx_end <= XW'(w_width);
    assign w_in_y      = w_by_end <= YW'(w_height);
    assign w_edge_x    = (w_bx_end + XW'(w_bin)) > XW'(w_width);
    assign w_edge_y    = (w_by_end + YW'(w_bin)) > YW'(w_height);
    assign w_ph_x_last = (BW'(r_ph_x) + BW'(1)) >= w_bin;
    assign w_ph_y_last = (BW'(r_ph_y) + BW'(1)) >= w_bin;
    assign w_col_last  = (r_col + CW'(1)) >= w_width;
    assign w_row_last  = (r_row + RW'(1)) >= w_height;

    always_comb begin
        o_ctl.in_span = w_in_x && w_in_y;
        o_ctl.fresh   = (r_ph_x == '0) && (r_ph_y == '0);
        o_ctl.emit    = w_in_x && w_in_y && w_ph_x_last && w_ph_y_last;
        o_ctl.last    = w_in_x && w_in_y && w_ph_x_last && w_ph_y_last && w_edge_x && w_edge_y;
    end

    assign o_addr = r_out_col;
    assign o_bin  = w_bin;

    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_ph_x    = r_ph_x;
        n_ph_y    = r_ph_y;
        n_out_col = r_out_col;
        if (w_restart) begin
            n_col     = '0;
            n_row     = '0;
            n_ph_x    = '0;
            n_ph_y    = '0;
            n_out_col = '0;
        end else if (i_accept) begin
            if (w_ph_x_last) begin
                n_ph_x    = '0;
                n_out_col = r_out_col + AW'(1);
            end else begin
                n_ph_x = r_ph_x + PW'(1);
            end
            if (w_col_last) begin
                n_col     = '0;
                n_ph_x    = '0;
                n_out_col = '0;
                n_ph_y    = w_ph_y_last ? '0 : r_ph_y + PW'(1);
                if (w_row_last) begin
                    n_row  = '0;
                    n_ph_y = '0;
                end else begin
                    n_row = r_row + RW'(1);
                end
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_ph_x    <= '0;
            r_ph_y    <= '0;
            r_out_col <= '0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_ph_x    <= n_ph_x;
            r_ph_y    <= n_ph_y;
            r_out_col <= n_out_col;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rbd_accum.sv =====
// column sum memory with read-modify-write and write-to-read forwarding
`timescale 1ns / 1ps
`default_nettype none

module rbd_accum #(
    parameter int MAX_WIDTH = rbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_BIN   = rbd_pkg::DEF_MAX_BIN
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_accept,
    input  logic [rbd_pkg::CHANNELS*rbd_pkg::PIX_W-1:0] i_pix,
    input  logic [$clog2(MAX_WIDTH)-1:0]               i_addr,
    input  rbd_pkg::t_pix_ctl                          i_ctl,
    output logic                                       o_free,
    input  logic                                       i_nxt_free,
    output logic                                       o_valid,
    output logic [rbd_pkg::CHANNELS*(rbd_pkg::PIX_W+$clog2(MAX_BIN*MAX_BIN))-1:0] o_sum,
    output logic                                       o_last
);
    import rbd_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int SW = PIX_W + $clog2(MAX_BIN * MAX_BIN);
    localparam int DW = CHANNELS * SW;

    logic [DW-1:0]             r_mem [MAX_WIDTH];
    logic [DW-1:0]             r_rdata;
    logic [DW-1:0]             r_fwd_sum;
    logic                      r_s1_valid;
    logic                      r_s1_hit;
    t_pix_ctl                  r_s1_ctl;
    logic [AW-1:0]             r_s1_addr;
    logic [CHANNELS*PIX_W-1:0] r_s1_pix;

    logic          w_s1_go;
    logic          w_wr;
    logic [DW-1:0] w_base;
    logic [DW-1:0] w_new;

    assign w_s1_go = r_s1_valid && (!r_s1_ctl.emit || i_nxt_free);
    assign o_free  = !r_s1_valid || w_s1_go;
    assign w_wr    = w_s1_go && r_s1_ctl.in_span;

    // the previous beat writes the same entry in the cycle this one reads it
    assign w_base = r_s1_hit ? r_fwd_sum : r_rdata;

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            if (r_s1_ctl.fresh) begin
                w_new[c*SW +: SW] = SW'(r_s1_pix[c*PIX_W +: PIX_W]);
            end else begin
                w_new[c*SW +: SW] = w_base[c*SW +: SW] + SW'(r_s1_pix[c*PIX_W +: PIX_W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_s1_addr] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_addr <= i_addr;
            r_s1_pix  <= i_pix;
            r_s1_ctl  <= i_ctl;
            r_s1_hit  <= w_wr && (r_s1_addr == i_addr);
            r_fwd_sum <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    assign o_valid = w_s1_go && r_s1_ctl.emit;
    assign o_sum   = w_new;
    assign o_last  = r_s1_ctl.last;

endmodule

`default_nettype wire

// ===== sv/rbd_scale.sv =====
// block sum to mean by reciprocal multiply, and the output register
`timescale 1ns / 1ps
`default_nettype none

module rbd_scale #(
    parameter int MAX_BIN = rbd_pkg::DEF_MAX_BIN
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic [$clog2(MAX_BIN+1)-1:0]               i_bin,
    input  logic                                       i_valid,
    input  logic [rbd_pkg::CHANNELS*(rbd_pkg::PIX_W+$clog2(MAX_BIN*MAX_BIN))-1:0] i_sum,
    input  logic                                       i_last,
    output logic                                       o_free,
    output logic                                       o_m_valid,
    input  logic                                       i_m_ready,
    output logic [rbd_pkg::CHANNELS*rbd_pkg::PIX_W-1:0] o_m_data,
    output logic                                       o_m_last
);
    import rbd_pkg::*;

    localparam int SW  = PIX_W + $clog2(MAX_BIN * MAX_BIN);
    localparam int K   = SW + $clog2(MAX_BIN * MAX_BIN);
    localparam int RCW = K + 1;
    localparam int PRW = SW + RCW;

    logic [RCW-1:0] w_recip [MAX_BIN+1];

    // ceil(2^K / area) gives an exact floor quotient for every block sum
    for (genvar g = 0; g <= MAX_BIN; g++) begin : g_recip
        localparam longint unsigned AREA = (g == 0) ? 64'd1 : 64'(g * g);
        localparam longint unsigned RVAL = ((64'd1 << K) + AREA - 64'd1) / AREA;
        assign w_recip[g] = RCW'(RVAL);
    end

    logic [RCW-1:0]          r_recip;
    logic                    r_s2_valid;
    logic [CHANNELS*SW-1:0]  r_s2_sum;
    logic                    r_s2_last;
    logic                    r_out_valid;
    logic [CHANNELS*PRW-1:0] r_out_prod;
    logic                    r_out_last;

    logic                    w_out_free;
    logic                    w_s2_go;
    logic [CHANNELS*PRW-1:0] w_prod;

    assign w_out_free = !r_out_valid || i_m_ready;
    assign w_s2_go    = r_s2_valid && w_out_free;
    assign o_free     = !r_s2_valid || w_out_free;

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            w_prod[c*PRW +: PRW] = PRW'(r_s2_sum[c*SW +: SW]) * PRW'(r_recip);
        end
    end

    always_ff @(posedge i_clk) begin
        r_recip <= w_recip[i_bin];
        if (i_valid) begin
            r_s2_sum  <= i_sum;
            r_s2_last <= i_last;
        end
        if (w_s2_go) begin
            r_out_prod <= w_prod;
            r_out_last <= r_s2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_valid) begin
                r_s2_valid <= 1'b1;
            end else if (w_s2_go) begin
                r_s2_valid <= 1'b0;
            end
            if (w_s2_go) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            o_m_data[c*PIX_W +: PIX_W] = r_out_prod[c*PRW + K +: PIX_W];
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_last  = r_out_last;

endmodule

`default_nettype wire
